@@ hdl/bccme_pkg.sv @@
// Shared types, constants and small lookup functions for the bounded coin
// change block. No dependencies; every other file imports this package.
package bccme_pkg;

  localparam int unsigned DENOM_COUNT     = 6;
  localparam int unsigned DENOM_UNITS [DENOM_COUNT] = '{1, 2, 4, 10, 20, 40};
  localparam int unsigned DEF_TABLE_DEPTH = 128;

  // Table entry: valid bit over an 8-bit coin count.
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned ENTRY_W  = COUNT_W + 1;
  // Wide enough for a saturated count plus greedy change at any depth up to 1024.
  localparam int unsigned SUM_W    = 10;
  localparam logic [COUNT_W-1:0] SAT_MAX = 8'd255;

  typedef struct packed {
    logic [6:0] price_units;
    logic [7:0] count_1;
    logic [7:0] count_2;
    logic [7:0] count_4;
    logic [7:0] count_10;
    logic [7:0] count_20;
    logic [7:0] count_40;
  } in_item_t;

  typedef struct packed {
    logic [7:0] fewest_coins;
    logic       unpayable;
  } out_item_t;

  // Operands of the shared add-and-compare unit.
  typedef struct packed {
    logic               lhs_valid;
    logic [COUNT_W-1:0] lhs;
    logic [SUM_W-1:0]   addend;
    logic               rhs_valid;
    logic [SUM_W-1:0]   rhs;
  } alu_op_t;

  typedef struct packed {
    logic             take;
    logic [SUM_W-1:0] sum;
  } alu_res_t;

  // Greedy coins for (tens mod 4) * 10 units: 0, 10, 20, 20+10.
  function automatic logic [1:0] greedy_tens(input logic [1:0] t);
    logic [1:0] n;
    unique case (t)
      2'd0:    n = 2'd0;
      2'd1:    n = 2'd1;
      2'd2:    n = 2'd1;
      default: n = 2'd2;
    endcase
    return n;
  endfunction

  // Greedy coins for a remainder below 10 using 4, 2 and 1.
  function automatic logic [1:0] greedy_ones(input logic [3:0] r);
    logic [1:0] n;
    unique case (r)
      4'd0:    n = 2'd0;
      4'd1:    n = 2'd1;
      4'd2:    n = 2'd1;
      4'd3:    n = 2'd2;
      4'd4:    n = 2'd1;
      4'd5:    n = 2'd2;
      4'd6:    n = 2'd2;
      4'd7:    n = 2'd3;
      4'd8:    n = 2'd2;
      4'd9:    n = 2'd3;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

  function automatic logic [COUNT_W-1:0] sat8(input logic [SUM_W-1:0] v);
    logic [COUNT_W-1:0] r;
    if (v > SUM_W'(SAT_MAX)) begin
      r = SAT_MAX;
    end else begin
      r = v[COUNT_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ hdl/bccme_table.sv @@
// Best-count table memory: one write port, two registered read ports.
// Depends on bccme_pkg for the entry width.
module bccme_table #(
  parameter int unsigned TABLE_DEPTH = bccme_pkg::DEF_TABLE_DEPTH,
  localparam int unsigned AW = $clog2(TABLE_DEPTH)
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [bccme_pkg::ENTRY_W-1:0] wr_data,
  input  logic [AW-1:0]                rd_addr_a,
  input  logic [AW-1:0]                rd_addr_b,
  output logic [bccme_pkg::ENTRY_W-1:0] rd_data_a,
  output logic [bccme_pkg::ENTRY_W-1:0] rd_data_b
);
  import bccme_pkg::*;

  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rd_a_r;
  logic [ENTRY_W-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

@@ hdl/bccme_alu.sv @@
// Shared add-and-compare unit: relaxes a table entry during the sweeps and
// tracks the running minimum during the final scan. Depends on bccme_pkg.
module bccme_alu (
  input  bccme_pkg::alu_op_t  op,
  output bccme_pkg::alu_res_t res
);
  import bccme_pkg::*;

  logic [SUM_W-1:0] sum;

  always_comb begin
    sum      = SUM_W'(op.lhs) + op.addend;
    res.sum  = sum;
    res.take = op.lhs_valid && (!op.rhs_valid || (sum < op.rhs));
  end

endmodule

@@ hdl/bccme_seq.sv @@
// Sequencer: clears the table, runs one descending sweep per usable coin,
// then scans sums at or above the price. Depends on bccme_pkg.
module bccme_seq #(
  parameter int unsigned TABLE_DEPTH = bccme_pkg::DEF_TABLE_DEPTH,
  localparam int unsigned AW = $clog2(TABLE_DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  bccme_pkg::in_item_t           item,
  output logic                          busy,
  output logic                          res_valid,
  input  logic                          res_take,
  output bccme_pkg::out_item_t          res,
  output logic                          wr_en,
  output logic [AW-1:0]                 wr_addr,
  output logic [bccme_pkg::ENTRY_W-1:0] wr_data,
  output logic [AW-1:0]                 rd_addr_a,
  output logic [AW-1:0]                 rd_addr_b,
  input  logic [bccme_pkg::ENTRY_W-1:0] rd_data_a,
  input  logic [bccme_pkg::ENTRY_W-1:0] rd_data_b,
  output bccme_pkg::alu_op_t            alu_op,
  input  bccme_pkg::alu_res_t           alu_res
);
  import bccme_pkg::*;

  localparam int unsigned DW = $clog2(DENOM_COUNT + 1);
  // Tens counter covers (TABLE_DEPTH-1)/10; denomination index 3 is the 10-unit coin.
  localparam int unsigned TW = $clog2((TABLE_DEPTH - 1) / DENOM_UNITS[3] + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);
  localparam logic [3:0]    LAST_ONES = 4'd9;
  localparam int unsigned USEFUL [DENOM_COUNT] = '{
    (TABLE_DEPTH - 1) / DENOM_UNITS[0], (TABLE_DEPTH - 1) / DENOM_UNITS[1],
    (TABLE_DEPTH - 1) / DENOM_UNITS[2], (TABLE_DEPTH - 1) / DENOM_UNITS[3],
    (TABLE_DEPTH - 1) / DENOM_UNITS[4], (TABLE_DEPTH - 1) / DENOM_UNITS[5]};

  localparam logic [3:0] ST_IDLE        = 4'd0;
  localparam logic [3:0] ST_CLEAR       = 4'd1;
  localparam logic [3:0] ST_NEXT        = 4'd2;
  localparam logic [3:0] ST_SWEEP       = 4'd3;
  localparam logic [3:0] ST_SWEEP_DRAIN = 4'd4;
  localparam logic [3:0] ST_SCAN_INIT   = 4'd5;
  localparam logic [3:0] ST_SCAN        = 4'd6;
  localparam logic [3:0] ST_SCAN_DRAIN  = 4'd7;
  localparam logic [3:0] ST_FINISH      = 4'd8;

  logic [3:0]         state_r,     state_nxt;
  logic [6:0]         price_r,     price_nxt;
  logic [7:0]         held_r [DENOM_COUNT];
  logic [7:0]         held_nxt [DENOM_COUNT];
  logic [DW-1:0]      den_r,       den_nxt;
  logic [7:0]         coin_r,      coin_nxt;
  logic [AW-1:0]      addr_r,      addr_nxt;
  logic               pipe_vld_r,  pipe_vld_nxt;
  logic [AW-1:0]      pipe_addr_r, pipe_addr_nxt;
  logic [TW-1:0]      tens_r,      tens_nxt;
  logic [3:0]         ones_r,      ones_nxt;
  logic [SUM_W-1:0]   gpipe_r,     gpipe_nxt;
  logic [SUM_W-1:0]   best_r,      best_nxt;
  logic               found_r,     found_nxt;

  logic [DW-1:0]      den_idx;
  logic [AW-1:0]      denom_v;
  logic               coin_more;
  logic               price_fits;
  logic [SUM_W-1:0]   greedy_now;
  logic               scan_phase;

  always_comb begin
    den_idx    = (32'(den_r) < DENOM_COUNT) ? den_r : '0;
    denom_v    = AW'(DENOM_UNITS[den_idx]);
    coin_more  = (coin_r < held_r[den_idx]) && (32'(coin_r) < USEFUL[den_idx]);
    price_fits = 32'(price_r) < TABLE_DEPTH;
    greedy_now = SUM_W'(tens_r >> 2) + SUM_W'(greedy_tens(tens_r[1:0]))
               + SUM_W'(greedy_ones(ones_r));
    scan_phase = (state_r == ST_SCAN) || (state_r == ST_SCAN_DRAIN);
  end

  // Operand select for the shared unit.
  always_comb begin
    if (scan_phase) begin
      alu_op.lhs_valid = rd_data_b[ENTRY_W-1];
      alu_op.lhs       = rd_data_b[COUNT_W-1:0];
      alu_op.addend    = gpipe_r;
      alu_op.rhs_valid = found_r;
      alu_op.rhs       = best_r;
    end else begin
      alu_op.lhs_valid = rd_data_a[ENTRY_W-1];
      alu_op.lhs       = rd_data_a[COUNT_W-1:0];
      alu_op.addend    = SUM_W'(1);
      alu_op.rhs_valid = rd_data_b[ENTRY_W-1];
      alu_op.rhs       = SUM_W'(rd_data_b[COUNT_W-1:0]);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    price_nxt     = price_r;
    held_nxt      = held_r;
    den_nxt       = den_r;
    coin_nxt      = coin_r;
    addr_nxt      = addr_r;
    pipe_vld_nxt  = 1'b0;
    pipe_addr_nxt = pipe_addr_r;
    tens_nxt      = tens_r;
    ones_nxt      = ones_r;
    gpipe_nxt     = gpipe_r;
    best_nxt      = best_r;
    found_nxt     = found_r;
    wr_en         = 1'b0;
    wr_addr       = pipe_addr_r;
    wr_data       = {1'b1, sat8(alu_res.sum)};
    rd_addr_a     = '0;
    rd_addr_b     = '0;
    res_valid     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          price_nxt   = item.price_units;
          held_nxt[0] = item.count_1;
          held_nxt[1] = item.count_2;
          held_nxt[2] = item.count_4;
          held_nxt[3] = item.count_10;
          held_nxt[4] = item.count_20;
          held_nxt[5] = item.count_40;
          addr_nxt    = '0;
          state_nxt   = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        // Only sum zero starts valid, with zero coins.
        wr_en   = 1'b1;
        wr_addr = addr_r;
        wr_data = {(addr_r == '0), COUNT_W'(0)};
        if (addr_r == LAST_ADDR) begin
          den_nxt   = '0;
          coin_nxt  = '0;
          state_nxt = ST_NEXT;
        end else begin
          addr_nxt = addr_r + AW'(1);
        end
      end
      ST_NEXT: begin
        if (32'(den_r) == DENOM_COUNT) begin
          state_nxt = ST_SCAN_INIT;
        end else if (coin_more) begin
          addr_nxt  = LAST_ADDR;
          state_nxt = ST_SWEEP;
        end else begin
          den_nxt  = den_r + DW'(1);
          coin_nxt = '0;
        end
      end
      ST_SWEEP: begin
        // Write back sum s+1 while reading s and s-v: no overlap going down.
        wr_en         = pipe_vld_r && alu_res.take;
        rd_addr_a     = addr_r - denom_v;
        rd_addr_b     = addr_r;
        pipe_vld_nxt  = 1'b1;
        pipe_addr_nxt = addr_r;
        if (addr_r == denom_v) begin
          state_nxt = ST_SWEEP_DRAIN;
        end else begin
          addr_nxt = addr_r - AW'(1);
        end
      end
      ST_SWEEP_DRAIN: begin
        wr_en     = pipe_vld_r && alu_res.take;
        coin_nxt  = coin_r + 8'd1;
        state_nxt = ST_NEXT;
      end
      ST_SCAN_INIT: begin
        found_nxt = 1'b0;
        best_nxt  = '0;
        tens_nxt  = '0;
        ones_nxt  = '0;
        if (price_fits) begin
          addr_nxt  = AW'(price_r);
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (pipe_vld_r && alu_res.take) begin
          best_nxt  = alu_res.sum;
          found_nxt = 1'b1;
        end
        rd_addr_b    = addr_r;
        pipe_vld_nxt = 1'b1;
        gpipe_nxt    = greedy_now;
        // Advance the change amount one unit, carrying into tens.
        if (ones_r == LAST_ONES) begin
          ones_nxt = '0;
          tens_nxt = tens_r + TW'(1);
        end else begin
          ones_nxt = ones_r + 4'd1;
        end
        if (addr_r == LAST_ADDR) begin
          state_nxt = ST_SCAN_DRAIN;
        end else begin
          addr_nxt = addr_r + AW'(1);
        end
      end
      ST_SCAN_DRAIN: begin
        if (pipe_vld_r && alu_res.take) begin
          best_nxt  = alu_res.sum;
          found_nxt = 1'b1;
        end
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res.unpayable    = !found_r;
    res.fewest_coins = found_r ? sat8(best_r) : 8'd0;
    busy             = (state_r != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      pipe_vld_r <= 1'b0;
      found_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pipe_vld_r <= pipe_vld_nxt;
      found_r    <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    price_r     <= price_nxt;
    held_r      <= held_nxt;
    den_r       <= den_nxt;
    coin_r      <= coin_nxt;
    addr_r      <= addr_nxt;
    pipe_addr_r <= pipe_addr_nxt;
    tens_r      <= tens_nxt;
    ones_r      <= ones_nxt;
    gpipe_r     <= gpipe_nxt;
    best_r      <= best_nxt;
  end

  a_wr_phase: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == ST_CLEAR || state_r == ST_SWEEP || state_r == ST_SWEEP_DRAIN))
    else $error("table written outside clear or sweep");

  a_sweep_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP && pipe_vld_r) |-> (pipe_addr_r > addr_r))
    else $error("sweep write-back not above the read address");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (state_r == ST_IDLE))
    else $error("item started while busy");

  a_found_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(found_r) |-> ($past(state_r) == ST_SCAN || $past(state_r) == ST_SCAN_DRAIN))
    else $error("minimum recorded outside the scan");

  a_finish_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_take) |=> (res_valid && $stable(res)))
    else $error("finished result dropped before hand-off");

endmodule

@@ hdl/bounded_coin_change_min_exchange.sv @@
// Top level of the bounded coin change block: input capture, output register,
// table memory, shared add-and-compare unit and sequencer. Depends on bccme_pkg.
//
//   Channel | Ports                        | Payload
//   --------+------------------------------+-------------------------------
//   input   | in_valid, in_stall, in_data  | price and six held coin counts
//   result  | out_valid, out_stall, out_data | fewest coins, unpayable flag
//
// One item at a time. An item first clears all D table entries, then for each
// denomination with value v and usable coin count n = min(held, (D-1)/v) runs
// n descending sweeps, one per coin, then scans the sums from the price up to
// D-1 (skipped for a price at or above D), where D is TABLE_DEPTH. The single
// table write port, one entry per cycle, limits the speed of the sweeps.
// Reset (rst_n low, synchronous) returns the sequencer to idle and empties the
// output register; the table is cleared at the start of every item, not at reset.
// in_stall is high from acceptance until the result moves into the output
// register; a result waiting on out_stall does not block the next item.
module bounded_coin_change_min_exchange #(
  parameter int unsigned TABLE_DEPTH = bccme_pkg::DEF_TABLE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  bccme_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bccme_pkg::out_item_t out_data
);
  import bccme_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic               busy;
  logic               start;
  logic               res_valid;
  logic               res_take;
  out_item_t          res;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [AW-1:0]      rd_addr_a;
  logic [AW-1:0]      rd_addr_b;
  logic [ENTRY_W-1:0] rd_data_a;
  logic [ENTRY_W-1:0] rd_data_b;
  alu_op_t            alu_op;
  alu_res_t           alu_res;

  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r,  out_data_nxt;

  // Accept only while the sequencer is idle.
  assign in_stall = busy;
  assign start    = in_valid && !busy;

  // Hand the result over when the output register is empty or draining.
  assign res_take = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid && res_take) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  bccme_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  bccme_alu u_alu (
    .op  (alu_op),
    .res (alu_res)
  );

  bccme_seq #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .item      (in_data),
    .busy      (busy),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .alu_op    (alu_op),
    .alu_res   (alu_res)
  );

endmodule

@@ dv/bounded_coin_change_min_exchange_tb.sv @@
// Self-checking testbench for bounded_coin_change_min_exchange: directed and random
// purchases, bursty sender, stalling receiver, in-bench predictor of the fewest coins.
// Depends on bccme_pkg and the block's RTL.
module bounded_coin_change_min_exchange_tb;
  import bccme_pkg::*;

  localparam int unsigned DEPTH          = DEF_TABLE_DEPTH;
  localparam int unsigned RANDOM_ITEMS   = 80;
  // Limit on consecutive cycles without a handshake; it must cover the sweeps of a saturated purchase.
  localparam int unsigned WATCHDOG_LIMIT = 150000;
  localparam int unsigned SETTLE_CYCLES  = 64;

  typedef struct {
    in_item_t purchase;
    bit       wait_for_drain;
  } queued_purchase_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  queued_purchase_t purchase_queue[$];
  out_item_t        expected_outcomes[$];
  out_item_t        oldest_outcome;

  bit          item_taken     = 1'b0;
  int unsigned burst_left     = 1;
  int unsigned gap_left       = 0;
  int unsigned stall_hold     = 0;
  logic [10:0] stall_phase    = '0;
  int unsigned quiet_cycles   = 0;
  int unsigned items_accepted = 0;
  int unsigned results_seen   = 0;
  int unsigned unpayable_seen = 0;
  int unsigned mismatches     = 0;

  bounded_coin_change_min_exchange dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // Coins handed back for an overpayment, largest denomination first.
  function automatic int unsigned change_coin_count(input int unsigned amount);
    int unsigned coins;
    int d;
    coins = 0;
    for (d = DENOM_COUNT - 1; d >= 0; d--) begin
      coins += amount / DENOM_UNITS[d];
      amount = amount % DENOM_UNITS[d];
    end
    return coins;
  endfunction

  // Fewest coins that change hands for one purchase.
  function automatic out_item_t predict_exchange(input in_item_t p);
    int unsigned held [DENOM_COUNT];
    int unsigned fewest_for_sum [DEPTH];
    bit          reachable [DEPTH];
    int unsigned value, usable, coin, cand, total, best;
    int          s, d;
    bit          found;
    out_item_t   r;
    held[0] = p.count_1;
    held[1] = p.count_2;
    held[2] = p.count_4;
    held[3] = p.count_10;
    held[4] = p.count_20;
    held[5] = p.count_40;
    for (s = 0; s < DEPTH; s++) begin
      fewest_for_sum[s] = 0;
      reachable[s]      = 1'b0;
    end
    reachable[0] = 1'b1;
    // Bounded knapsack: one descending sweep per usable coin, so each coin counts once.
    for (d = 0; d < DENOM_COUNT; d++) begin
      value  = DENOM_UNITS[d];
      usable = (DEPTH - 1) / value;
      if (held[d] < usable) begin
        usable = held[d];
      end
      for (coin = 0; coin < usable; coin++) begin
        for (s = DEPTH - 1; s >= int'(value); s--) begin
          if (reachable[s - value]) begin
            cand = fewest_for_sum[s - value] + 1;
            if (!reachable[s] || cand < fewest_for_sum[s]) begin
              fewest_for_sum[s] = (cand > 255) ? 255 : cand;
              reachable[s]      = 1'b1;
            end
          end
        end
      end
    end
    // Best over every payable sum at or above the price, change included.
    found = 1'b0;
    best  = 0;
    for (s = int'(p.price_units); s < DEPTH; s++) begin
      if (reachable[s]) begin
        total = fewest_for_sum[s] + change_coin_count(s - p.price_units);
        if (!found || total < best) begin
          best  = total;
          found = 1'b1;
        end
      end
    end
    r.fewest_coins = found ? ((best > 255) ? 8'd255 : best[7:0]) : 8'd0;
    r.unpayable    = !found;
    return r;
  endfunction

  task automatic add_purchase(input int unsigned price, input int unsigned c1,
                              input int unsigned c2, input int unsigned c4,
                              input int unsigned c10, input int unsigned c20,
                              input int unsigned c40, input bit drain_first);
    queued_purchase_t q;
    q.purchase.price_units = price[6:0];
    q.purchase.count_1     = c1[7:0];
    q.purchase.count_2     = c2[7:0];
    q.purchase.count_4     = c4[7:0];
    q.purchase.count_10    = c10[7:0];
    q.purchase.count_20    = c20[7:0];
    q.purchase.count_40    = c40[7:0];
    q.wait_for_drain       = drain_first;
    purchase_queue.push_back(q);
  endtask

  // Small holdings keep the sweep short; zero some out to reach unpayable prices.
  function automatic int unsigned random_count(input bit full_range);
    int unsigned c;
    if (full_range) begin
      c = $urandom_range(0, 255);
    end else if ($urandom_range(0, 3) == 0) begin
      c = 0;
    end else begin
      c = $urandom_range(1, 9);
    end
    return c;
  endfunction

  // Driver: advance on the falling edge once the current item is taken.
  // Items go out in bursts; a gap of idle cycles follows most bursts.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || item_taken) begin
      item_taken = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (purchase_queue.size() != 0 &&
                   !(purchase_queue[0].wait_for_drain && expected_outcomes.size() != 0)) begin
        in_data  <= purchase_queue[0].purchase;
        in_valid <= 1'b1;
        purchase_queue.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 6);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        end else begin
          burst_left--;
        end
      end else begin
        // Hold off: queue empty, or waiting for every outstanding result.
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: calm stretches with no stall, otherwise random stall runs.
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1'b1;
    if (stall_hold != 0) begin
      out_stall  <= 1'b1;
      stall_hold <= stall_hold - 1;
    end else if (!rst_n || stall_phase[10:9] == 2'b00) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall  <= 1'b1;
      stall_hold <= $urandom_range(0, 15);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: sample both channels on the rising edge. Check the result first so
  // an item accepted in the same cycle is never matched against its own result.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_outcomes.size() == 0) begin
          $display("%0t: unexpected result fewest_coins=%0d unpayable=%0b",
                   $time, out_data.fewest_coins, out_data.unpayable);
          mismatches++;
        end else begin
          oldest_outcome = expected_outcomes.pop_front();
          if (oldest_outcome.unpayable) begin
            unpayable_seen++;
          end
          if (out_data.fewest_coins !== oldest_outcome.fewest_coins) begin
            $display("%0t: fewest_coins expected %0d actual %0d", $time,
                     oldest_outcome.fewest_coins, out_data.fewest_coins);
            mismatches++;
          end
          if (out_data.unpayable !== oldest_outcome.unpayable) begin
            $display("%0t: unpayable expected %0b actual %0b", $time,
                     oldest_outcome.unpayable, out_data.unpayable);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_outcomes.push_back(predict_exchange(in_data));
        item_taken = 1'b1;
        items_accepted++;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
  end

  initial begin
    int unsigned n, settle;
    bit          full, timed_out;
    timed_out = 1'b0;

    // Directed: empty purse, full purse, one coin of each kind, change cases,
    // price beyond what 40s alone can cover, and alternating bit patterns.
    add_purchase(0,   0,   0,   0,   0,   0,   0,   1'b0);
    add_purchase(1,   0,   0,   0,   0,   0,   0,   1'b0);
    add_purchase(127, 0,   0,   0,   0,   0,   0,   1'b0);
    add_purchase(0,   255, 255, 255, 255, 255, 255, 1'b0);
    add_purchase(127, 255, 255, 255, 255, 255, 255, 1'b0);
    add_purchase(1,   1,   0,   0,   0,   0,   0,   1'b0);
    add_purchase(2,   0,   1,   0,   0,   0,   0,   1'b0);
    add_purchase(4,   0,   0,   1,   0,   0,   0,   1'b0);
    add_purchase(10,  0,   0,   0,   1,   0,   0,   1'b0);
    add_purchase(20,  0,   0,   0,   0,   1,   0,   1'b0);
    add_purchase(40,  0,   0,   0,   0,   0,   1,   1'b0);
    add_purchase(3,   0,   0,   1,   0,   0,   0,   1'b0);
    add_purchase(7,   0,   0,   0,   1,   0,   0,   1'b0);
    add_purchase(127, 0,   0,   0,   0,   0,   255, 1'b0);
    add_purchase(120, 0,   0,   0,   0,   0,   255, 1'b0);
    add_purchase(120, 0,   0,   0,   0,   0,   3,   1'b0);
    add_purchase(64,  0,   0,   0,   0,   0,   2,   1'b0);
    add_purchase(126, 1,   1,   1,   1,   1,   3,   1'b0);
    add_purchase(85,  'h55, 'hAA, 'h55, 'hAA, 'h55, 'hAA, 1'b0);
    add_purchase(42,  'hAA, 'h55, 'hAA, 'h55, 'hAA, 'h55, 1'b0);

    // Random: mostly small holdings, now and then full-range counts.
    // Twice the sender holds off until every result is back.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      full = ($urandom_range(0, 11) == 0);
      add_purchase($urandom_range(0, 127), random_count(full), random_count(full),
                   random_count(full), random_count(full), random_count(full),
                   random_count(full), (n == 0) || (n == RANDOM_ITEMS / 2));
    end

    // Synchronous reset, released on a falling edge.
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (!timed_out && !(purchase_queue.size() == 0 && !in_valid &&
                           expected_outcomes.size() == 0)) begin
      @(posedge clk);
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        timed_out = 1'b1;
      end
    end

    if (timed_out) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, expected_outcomes.size());
      $display("Verification failed");
    end else begin
      // Watch for stray results after the last expected one.
      for (settle = 0; settle < SETTLE_CYCLES; settle++) begin
        @(posedge clk);
      end
      if (expected_outcomes.size() != 0) begin
        $display("%0t: %0d expected results never arrived", $time,
                 expected_outcomes.size());
      end
      $display("Run covered %0d purchases and %0d results, %0d of them unpayable.",
               items_accepted, results_seen, unpayable_seen);
      if (mismatches == 0 && expected_outcomes.size() == 0) begin
        $display("Verification passed");
      end else begin
        $display("Verification failed");
      end
    end
    $finish;
  end

endmodule
